FILE: sv/dcgl_pkg.sv
// Shared constants and types for the decimal counter glyph layout block.
`timescale 1ns / 1ps
`default_nettype none
package dcgl_pkg;

  // Number base and the glyph code of the minus sign
  localparam int unsigned RADIX       = 10;
  localparam logic [3:0]  MINUS_GLYPH = 4'd10;

  // Default longest magnitude kept, in digits
  localparam int unsigned DEFAULT_MAX_DIGITS = 10;

  // Divide by ten: q = (x * RECIP_TEN) >> RECIP_SHIFT, exact for any 32-bit x
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // Field widths
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned GLYPH_W   = 4;
  localparam int unsigned SCREEN_W  = 14;
  localparam int unsigned TEXU_W    = 13;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 12;
  localparam int unsigned OUT_DAT_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_DIGITS    = 3'd0,
    REG_RIGHT_TO_LEFT = 3'd1,
    REG_CELL_WIDTH    = 3'd2,
    REG_ATLAS_X       = 3'd3,
    REG_ORIGIN_X      = 3'd4,
    REG_CELL_HEIGHT   = 3'd5,
    REG_ATLAS_Y       = 3'd6,
    REG_ORIGIN_Y      = 3'd7
  } cfg_reg_t;

endpackage : dcgl_pkg
`default_nettype wire

FILE: sv/decimal_counter_glyph_layout.sv
// Decimal digit layout: splits a signed value into glyphs and places them in a row.
//
// Usage: the slave stream (s_axis_*) takes one 32-bit signed value per item.
// The block turns its magnitude into decimal digits, pads with leading zeros
// up to min_digits, adds a minus glyph for negative values and sends one item
// per glyph on the master stream (m_axis_*), with tlast on the final glyph.
// Glyphs go left to right from the most significant one, or right to left
// from the least significant one when right_to_left is set.
// The cfg_* channel writes the layout registers; it is always ready and is
// meant to be written only while the block is idle.
// Steps: the value is accepted while idle; each digit found (up to MAX_DIGITS)
// takes a multiply step and a remainder step; each pad digit takes a pad step,
// and one more pad step closes the string; then one glyph goes out per cycle
// while the receiver takes them (up to MAX_DIGITS+1 glyphs). A new value is
// accepted once the final glyph is loaded into the output register. The digit
// loop runs on the one shared 32x32 reciprocal multiplier (multiply, then
// remainder).
// s_axis_tready is high only while idle. A stalled receiver holds the output
// register, and the glyph sequencer waits with it. A synchronous rst clears the
// sequencer, the output valid, the configuration registers, neg, mag and nd.
`timescale 1ns / 1ps
`default_nettype none
module decimal_counter_glyph_layout #(
  parameter int unsigned MAX_DIGITS = dcgl_pkg::DEFAULT_MAX_DIGITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // value (32, signed)
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [dcgl_pkg::VALUE_W-1:0]    s_axis_tdata,
  // glyph [3:0], screen_x [17:4] (signed), tex_u [30:18], zero [31]
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [dcgl_pkg::OUT_DAT_W-1:0]       m_axis_tdata,
  output logic                                 m_axis_tlast,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [dcgl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dcgl_pkg::CFG_DAT_W-1:0]  cfg_data
);
  import dcgl_pkg::*;

  localparam int unsigned DEPTH = MAX_DIGITS + 1;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 2);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_REM  = 5'b00100,
    ST_PAD  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  // Configuration registers (cell height, atlas y, origin y feed no result)
  logic [3:0]          min_digits;
  logic                right_to_left;
  logic [7:0]          cell_width;
  logic [11:0]         atlas_x;
  logic [11:0]         origin_x;

  // Sequencer and working state
  state_t              state;
  logic [VALUE_W-1:0]  mag;
  logic [2*VALUE_W-1:0] prod;
  logic                neg;
  logic [CNT_W-1:0]    nd;
  logic [CNT_W-1:0]    emit_left;
  logic [IDX_W-1:0]    rd_idx;
  logic [SCREEN_W-1:0] sx;
  logic [GLYPH_W-1:0]  digit_store [DEPTH];

  // Output register
  logic [GLYPH_W-1:0]  out_glyph;
  logic [SCREEN_W-1:0] out_sx;
  logic [TEXU_W-1:0]   out_texu;
  logic                out_last;

  // Combinational helpers
  logic [VALUE_W-1:0]  quo;
  logic [VALUE_W-1:0]  rem_full;
  logic [CNT_W-1:0]    pad;
  logic [CNT_W-1:0]    nd_inc;
  logic [CNT_W-1:0]    glyph_total;
  logic                out_load;
  logic                in_fire;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  // Quotient from the registered product; remainder is x - 10q
  assign quo      = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
  assign rem_full = mag - ((quo << 3) + (quo << 1));
  assign nd_inc   = nd + CNT_W'(1);

  // Padding target saturates at the longest kept magnitude
  assign pad = (32'(min_digits) > 32'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                   : CNT_W'(min_digits);
  assign glyph_total = nd + CNT_W'(neg);

  // In the emit state the output register loads while empty or while its item is taken
  assign out_load  = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_digits    <= 4'd0;
      right_to_left <= 1'b0;
      cell_width    <= 8'd8;
      atlas_x       <= 12'd0;
      origin_x      <= 12'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_DIGITS:    min_digits    <= cfg_data[3:0];
        REG_RIGHT_TO_LEFT: right_to_left <= cfg_data[0];
        REG_CELL_WIDTH:    cell_width    <= cfg_data[7:0];
        REG_ATLAS_X:       atlas_x       <= cfg_data;
        REG_ORIGIN_X:      origin_x      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: digit loop, padding, glyph emission
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_REM;
        end
        ST_REM: begin
          if (quo == '0 || 32'(nd_inc) >= 32'(MAX_DIGITS)) begin
            state <= ST_PAD;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_PAD: begin
          if (!(nd < pad)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load && emit_left == CNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      neg <= 1'b0;
      mag <= '0;
      nd  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            neg <= s_axis_tdata[VALUE_W-1];
            mag <= s_axis_tdata[VALUE_W-1] ? (~s_axis_tdata + VALUE_W'(1)) : s_axis_tdata;
            nd  <= '0;
          end
        end
        ST_MUL: begin
          prod <= mag * RECIP_TEN;
        end
        ST_REM: begin
          digit_store[nd[IDX_W-1:0]] <= rem_full[GLYPH_W-1:0];
          nd  <= nd_inc;
          mag <= quo;
        end
        ST_PAD: begin
          if (nd < pad) begin
            digit_store[nd[IDX_W-1:0]] <= '0;
            nd <= nd_inc;
          end else begin
            // close the string: minus sits above the top digit
            if (neg) begin
              digit_store[nd[IDX_W-1:0]] <= MINUS_GLYPH;
            end
            emit_left <= glyph_total;
            rd_idx    <= right_to_left ? '0 : IDX_W'(glyph_total - CNT_W'(1));
            sx        <= SCREEN_W'(origin_x);
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            emit_left <= emit_left - CNT_W'(1);
            rd_idx    <= right_to_left ? rd_idx + IDX_W'(1) : rd_idx - IDX_W'(1);
            sx        <= right_to_left ? sx - SCREEN_W'(cell_width)
                                       : sx + SCREEN_W'(cell_width);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Glyph read and atlas position
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_glyph <= digit_store[rd_idx];
      out_sx    <= sx;
      out_texu  <= TEXU_W'(atlas_x)
                   + TEXU_W'(digit_store[rd_idx]) * TEXU_W'(cell_width);
      out_last  <= (emit_left == CNT_W'(1));
    end
  end

  assign m_axis_tdata = {1'b0, out_texu, out_sx, out_glyph};
  assign m_axis_tlast = out_last;

  // Checks
  a_nd_bound: assert property (@(posedge clk) disable iff (rst)
    32'(nd) <= 32'(MAX_DIGITS))
    else $error("digit count beyond store");

  a_accept_starts_loop: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ST_MUL)
    else $error("accepted value did not start the digit loop");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_load && emit_left == CNT_W'(1)) |=> (state == ST_IDLE && m_axis_tlast))
    else $error("final glyph did not close the value");

  a_glyph_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_glyph <= MINUS_GLYPH)
    else $error("glyph code out of range");

  a_emit_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> emit_left != '0)
    else $error("emission with no glyph left");

endmodule : decimal_counter_glyph_layout
`default_nettype wire
